/* rtl/bvm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bvm_pkg
// Shared types and constants of the battery voltage monitor.
// ----------------------------------------------------------------------------
package bvm_pkg;

    // Field widths
    localparam int ADC_W    = 10;
    localparam int CNT_W    = 16;
    localparam int LVL_CFG_W = 12;
    localparam int CONF_W   = 3;
    localparam int AVG_W    = 10;
    localparam int PROD_W   = 21;
    localparam int M_W      = 11;
    localparam int LEVEL_W  = 11;
    localparam int TENTHS_W = 8;
    localparam int CFG_IDX_W = 3;

    // Scaling constants
    localparam int ADC_MAX      = 1023;
    localparam logic [M_W-1:0] FULL_SCALE = 11'd1886;
    localparam logic [LEVEL_W-1:0] OFFSET_HUNDREDTHS = 11'd50;
    localparam logic [M_W:0] DIV1023_ONE = 12'd1023;
    localparam logic [M_W:0] DIV1023_TWO = 12'd2046;
    localparam int TENTHS_SHIFT = 15;
    localparam logic [11:0] TENTHS_RECIP = 12'd3277;
    localparam logic [8:0] TENTHS_BIAS = 9'd5;
    localparam logic [8:0] TENTHS_MAX = 9'd255;
    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    // Register reset values
    localparam logic [CNT_W-1:0]     RST_SAMPLE_PERIOD  = 16'd100;
    localparam logic [CNT_W-1:0]     RST_CHECK_PERIOD   = 16'd1000;
    localparam logic [CNT_W-1:0]     RST_BEEP_PERIOD    = 16'd200;
    localparam logic [LVL_CFG_W-1:0] RST_NOMINAL_LEVEL  = 12'd1110;
    localparam logic [LVL_CFG_W-1:0] RST_CUTOFF_LEVEL   = 12'd222;
    localparam logic [CONF_W-1:0]    RST_CONFIRM_CHECKS = 3'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_PERIOD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_PERIOD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_LEVEL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_CHECKS = 3'd5;

    // Power machine states
    typedef enum logic [2:0] {
        PS_OFF     = 3'd0,
        PS_STARTUP = 3'd1,
        PS_NORMAL  = 3'd2,
        PS_CHECK   = 3'd3,
        PS_WARNING = 3'd4
    } mode_t;

    // Side information that travels with a tick down the level pipeline
    typedef struct packed {
        logic have_sample;
        logic check_fire;
    } tag_t;

endpackage
`default_nettype wire

/* rtl/bvm_level.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bvm_level
// Pipeline that turns the ring sum into the level in hundredths of a volt
// and the reported voltage in tenths of a volt.
// ----------------------------------------------------------------------------
module bvm_level
    import bvm_pkg::*;
#(
    parameter int WINDOW_LEN = 10,
    parameter int SUM_W      = 14
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_vld,
    input  wire logic [SUM_W-1:0]   in_sum,
    input  wire tag_t               in_tag,
    output logic                    lvl_vld,
    output logic [LEVEL_W-1:0]      lvl_level,
    output logic [TENTHS_W-1:0]     lvl_tenths,
    output tag_t                    lvl_tag
);

    // Reciprocal of the window length, exact for every reachable sum
    localparam int AVG_SHIFT = SUM_W + 4;
    localparam int RECIP_W   = AVG_SHIFT + 1;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'((2 ** AVG_SHIFT + WINDOW_LEN - 1) / WINDOW_LEN);

    logic                   v_avg_reg, v_prod_reg, v_m_reg, v_out_reg;
    tag_t                   t_avg_reg, t_prod_reg, t_m_reg, t_out_reg;
    logic [AVG_W-1:0]       avg_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [M_W-1:0]         m_reg;
    logic [LEVEL_W-1:0]     level_reg;
    logic [TENTHS_W-1:0]    tenths_reg;

    logic [SUM_W+RECIP_W-1:0] avg_prod;
    logic [AVG_W-1:0]       avg_next;
    logic [PROD_W-1:0]      prod_next;
    logic [M_W-1:0]         q0;
    logic [M_W:0]           rem;
    logic [M_W-1:0]         m_next;
    logic [M_W+11:0]        tenths_prod;
    logic [8:0]             tenths_sum;
    logic [LEVEL_W-1:0]     level_next;
    logic [TENTHS_W-1:0]    tenths_next;

    // Average: multiply by the reciprocal of the window length
    assign avg_prod = SUM_W'(in_sum) * AVG_RECIP;
    assign avg_next = avg_prod[AVG_SHIFT +: AVG_W];

    // Full-scale product
    assign prod_next = PROD_W'(avg_reg) * PROD_W'(FULL_SCALE);

    // Division by 1023: quotient by 1024 plus a small correction
    always_comb
    begin
        q0  = prod_reg[PROD_W-1:10];
        rem = (M_W+1)'(prod_reg[9:0]) + (M_W+1)'(q0);
        if (rem >= DIV1023_TWO)
        begin
            m_next = q0 + M_W'(2);
        end
        else if (rem >= DIV1023_ONE)
        begin
            m_next = q0 + M_W'(1);
        end
        else
        begin
            m_next = q0;
        end
    end

    // Level and reported tenths; both read zero until the first sample
    always_comb
    begin
        tenths_prod = (M_W+12)'(m_reg) * (M_W+12)'(TENTHS_RECIP);
        tenths_sum  = 9'(tenths_prod[TENTHS_SHIFT +: 8]) + TENTHS_BIAS;
        if (!t_m_reg.have_sample)
        begin
            level_next  = '0;
            tenths_next = '0;
        end
        else
        begin
            level_next  = LEVEL_W'(m_reg) + OFFSET_HUNDREDTHS;
            tenths_next = (tenths_sum > TENTHS_MAX) ? TENTHS_W'(TENTHS_MAX)
                                                    : tenths_sum[TENTHS_W-1:0];
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_avg_reg  <= 1'b0;
            v_prod_reg <= 1'b0;
            v_m_reg    <= 1'b0;
            v_out_reg  <= 1'b0;
        end
        else if (en)
        begin
            v_avg_reg  <= in_vld;
            v_prod_reg <= v_avg_reg;
            v_m_reg    <= v_prod_reg;
            v_out_reg  <= v_m_reg;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            avg_reg    <= avg_next;
            t_avg_reg  <= in_tag;
            prod_reg   <= prod_next;
            t_prod_reg <= t_avg_reg;
            m_reg      <= m_next;
            t_m_reg    <= t_prod_reg;
            level_reg  <= level_next;
            tenths_reg <= tenths_next;
            t_out_reg  <= t_m_reg;
        end
    end

    assign lvl_vld    = v_out_reg;
    assign lvl_level  = level_reg;
    assign lvl_tenths = tenths_reg;
    assign lvl_tag    = t_out_reg;

endmodule
`default_nettype wire

/* rtl/bvm_power.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bvm_power
// Five-state power machine, beep pacing and the result register.
// ----------------------------------------------------------------------------
module bvm_power
    import bvm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  lvl_vld,
    input  wire logic [LEVEL_W-1:0]    lvl_level,
    input  wire logic [TENTHS_W-1:0]   lvl_tenths,
    input  wire tag_t                  lvl_tag,
    input  wire logic [CNT_W-1:0]      beep_period,
    input  wire logic [LVL_CFG_W-1:0]  nominal_level,
    input  wire logic [LVL_CFG_W-1:0]  cutoff_level,
    input  wire logic [CONF_W-1:0]     confirm_checks,
    output logic                       res_valid,
    output logic [TENTHS_W-1:0]        res_tenths,
    output mode_t                      res_mode,
    output logic                       res_beep
);

    mode_t                  mode_reg, mode_next;
    logic [CONF_W-1:0]      confirm_reg, confirm_next;
    logic [CNT_W-1:0]       since_beep_reg, since_beep_next;
    logic                   valid_reg;
    logic                   beep_reg, beep_next;
    logic [TENTHS_W-1:0]    tenths_reg;
    logic [LVL_CFG_W-1:0]   lv;
    logic [CNT_W-1:0]       beep_bump;

    assign lv = LVL_CFG_W'(lvl_level);

    // Next state of the power machine
    always_comb
    begin
        mode_next    = mode_reg;
        confirm_next = confirm_reg;
        if (lvl_tag.check_fire)
        begin
            case (mode_reg)
                PS_OFF:
                begin
                    if (lv > cutoff_level)
                    begin
                        mode_next = PS_STARTUP;
                    end
                end
                PS_STARTUP:
                begin
                    mode_next = (lv > nominal_level) ? PS_NORMAL : PS_CHECK;
                end
                PS_NORMAL:
                begin
                    if (lv < nominal_level)
                    begin
                        mode_next    = PS_CHECK;
                        confirm_next = '0;
                    end
                end
                PS_CHECK:
                begin
                    if (confirm_reg < confirm_checks)
                    begin
                        confirm_next = confirm_reg + CONF_W'(1);
                    end
                    else if (lv < nominal_level)
                    begin
                        mode_next = PS_WARNING;
                    end
                    if (lv >= nominal_level)
                    begin
                        mode_next = PS_NORMAL;
                    end
                end
                PS_WARNING:
                begin
                    if (lv > nominal_level)
                    begin
                        mode_next = PS_NORMAL;
                    end
                    if (lv < cutoff_level)
                    begin
                        mode_next = PS_OFF;
                    end
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // Beep pacing, judged on the state after this tick's evaluation
    always_comb
    begin
        beep_bump = (since_beep_reg == CNT_MAX) ? CNT_MAX : since_beep_reg + CNT_W'(1);
        if (mode_next == PS_WARNING && beep_bump >= beep_period)
        begin
            beep_next       = 1'b1;
            since_beep_next = '0;
        end
        else
        begin
            beep_next       = 1'b0;
            since_beep_next = beep_bump;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= PS_STARTUP;
            confirm_reg    <= '0;
            since_beep_reg <= '0;
            valid_reg      <= 1'b0;
            beep_reg       <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= lvl_vld;
            if (lvl_vld)
            begin
                mode_reg       <= mode_next;
                confirm_reg    <= confirm_next;
                since_beep_reg <= since_beep_next;
                beep_reg       <= beep_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (en && lvl_vld)
        begin
            tenths_reg <= lvl_tenths;
        end
    end

    assign res_valid  = valid_reg;
    assign res_tenths = tenths_reg;
    assign res_mode   = mode_reg;
    assign res_beep   = beep_reg;

endmodule
`default_nettype wire

/* rtl/battery_voltage_monitor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// battery_voltage_monitor
// Averages ADC readings of the battery over a ring of samples, reports the
// voltage in tenths of a volt and runs a five-state power machine with a
// paced warning beep.
// ----------------------------------------------------------------------------
// Each input transaction is one millisecond tick. The block takes one tick
// per clock cycle while in_stall is low and returns one result transaction
// per tick. A tick passes in order through the tick counters, the sample
// ring and the first stage register, the averaging and scaling pipeline
// (reciprocal multiply, full-scale multiply, division by 1023, tenths
// scaling) and the power machine and result register. While a result is
// held by out_stall the whole pipeline holds and in_stall is raised.
// Registers are written through cfg_we, cfg_index and cfg_data and take
// effect at once; there is no clearing pass after reset.
module battery_voltage_monitor
    import bvm_pkg::*;
#(
    parameter int WINDOW_LEN = 10
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [ADC_W-1:0]       adc_sample,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [TENTHS_W-1:0]         voltage_tenths,
    output logic [2:0]                  power_state,
    output logic                        beep_start,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CNT_W-1:0]       cfg_data
);

    localparam int SUM_W = $clog2(WINDOW_LEN * ADC_MAX + 1);
    localparam int POS_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);
    localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_W'(WINDOW_LEN * ADC_MAX);

    // Configuration registers
    logic [CNT_W-1:0]       sample_period_reg;
    logic [CNT_W-1:0]       check_period_reg;
    logic [CNT_W-1:0]       beep_period_reg;
    logic [LVL_CFG_W-1:0]   nominal_level_reg;
    logic [LVL_CFG_W-1:0]   cutoff_level_reg;
    logic [CONF_W-1:0]      confirm_checks_reg;

    // Tick state
    logic [ADC_W-1:0]       ring_reg [WINDOW_LEN];
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic                   have_reg, have_next;
    logic [CNT_W-1:0]       since_sample_reg, since_sample_next;
    logic [CNT_W-1:0]       since_check_reg, since_check_next;
    logic [CNT_W-1:0]       sample_bump, check_bump;
    logic                   sample_fire, check_fire;

    // First pipeline stage
    logic                   s1_valid_reg;
    logic [SUM_W-1:0]       s1_sum_reg;
    tag_t                   s1_tag_reg;

    logic                   adv;
    logic                   accept;
    logic                   lvl_vld;
    logic [LEVEL_W-1:0]     lvl_level;
    logic [TENTHS_W-1:0]    lvl_tenths;
    tag_t                   lvl_tag;
    mode_t                  res_mode;

    // The pipeline moves whenever the result register can take a new value
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;
    assign accept   = in_valid && adv;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg  <= RST_SAMPLE_PERIOD;
            check_period_reg   <= RST_CHECK_PERIOD;
            beep_period_reg    <= RST_BEEP_PERIOD;
            nominal_level_reg  <= RST_NOMINAL_LEVEL;
            cutoff_level_reg   <= RST_CUTOFF_LEVEL;
            confirm_checks_reg <= RST_CONFIRM_CHECKS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SAMPLE_PERIOD:  sample_period_reg  <= cfg_data;
                CFG_CHECK_PERIOD:   check_period_reg   <= cfg_data;
                CFG_BEEP_PERIOD:    beep_period_reg    <= cfg_data;
                CFG_NOMINAL_LEVEL:  nominal_level_reg  <= cfg_data[LVL_CFG_W-1:0];
                CFG_CUTOFF_LEVEL:   cutoff_level_reg   <= cfg_data[LVL_CFG_W-1:0];
                CFG_CONFIRM_CHECKS: confirm_checks_reg <= cfg_data[CONF_W-1:0];
                default:            ;
            endcase
        end
    end

    // Elapsed-tick counters and the sample decision
    always_comb
    begin
        sample_bump = (since_sample_reg == CNT_MAX) ? CNT_MAX
                                                    : since_sample_reg + CNT_W'(1);
        check_bump  = (since_check_reg == CNT_MAX) ? CNT_MAX
                                                   : since_check_reg + CNT_W'(1);
        sample_fire = sample_bump > sample_period_reg;
        check_fire  = check_bump > check_period_reg;
        since_sample_next = sample_fire ? '0 : sample_bump;
        since_check_next  = check_fire ? '0 : check_bump;
    end

    // Ring update: replace the oldest reading and adjust the running sum
    always_comb
    begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        have_next = have_reg;
        if (sample_fire)
        begin
            sum_next  = sum_reg - SUM_W'(ring_reg[pos_reg]) + SUM_W'(adc_sample);
            pos_next  = (pos_reg == POS_LAST) ? '0 : pos_reg + POS_W'(1);
            have_next = 1'b1;
        end
    end

    // Tick state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                ring_reg[i] <= '0;
            end
            pos_reg          <= '0;
            sum_reg          <= '0;
            have_reg         <= 1'b0;
            since_sample_reg <= '0;
            since_check_reg  <= '0;
        end
        else if (accept)
        begin
            if (sample_fire)
            begin
                ring_reg[pos_reg] <= adc_sample;
            end
            pos_reg          <= pos_next;
            sum_reg          <= sum_next;
            have_reg         <= have_next;
            since_sample_reg <= since_sample_next;
            since_check_reg  <= since_check_next;
        end
    end

    // First stage of the level pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sum_reg             <= sum_next;
            s1_tag_reg.have_sample <= have_next;
            s1_tag_reg.check_fire  <= check_fire;
        end
    end

    // Averaging and scaling
    bvm_level #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W)
    ) u_level (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_vld     (s1_valid_reg),
        .in_sum     (s1_sum_reg),
        .in_tag     (s1_tag_reg),
        .lvl_vld    (lvl_vld),
        .lvl_level  (lvl_level),
        .lvl_tenths (lvl_tenths),
        .lvl_tag    (lvl_tag)
    );

    // Power machine and result register
    bvm_power u_power (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (adv),
        .lvl_vld        (lvl_vld),
        .lvl_level      (lvl_level),
        .lvl_tenths     (lvl_tenths),
        .lvl_tag        (lvl_tag),
        .beep_period    (beep_period_reg),
        .nominal_level  (nominal_level_reg),
        .cutoff_level   (cutoff_level_reg),
        .confirm_checks (confirm_checks_reg),
        .res_valid      (out_valid),
        .res_tenths     (voltage_tenths),
        .res_mode       (res_mode),
        .res_beep       (beep_start)
    );

    assign power_state = res_mode;

`ifndef SYNTHESIS
    // A beep is only ever reported in the warning state.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && beep_start |-> power_state == PS_WARNING)
        else $error("beep outside warning state");

    // The ring pointer stays inside the window.
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("ring position out of range");

    // The running sum never exceeds a full window of maximum readings.
    assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUM_LIMIT)
        else $error("ring sum out of range");

    // Power state changes only when a result transaction advances.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(adv) |-> $stable(power_state))
        else $error("power state changed while pipeline held");
`endif

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the battery voltage monitor. A short table of
// directed ticks goes first, then about 1600 random ticks in phases with
// different register settings. Every accepted tick is run through a
// behavioral copy of the averaging ring and the power machine, and every
// result transaction is compared field by field with the oldest expected reading.
// ----------------------------------------------------------------------------
module tb;
    import bvm_pkg::*;

    localparam int WINDOW        = 10;
    localparam int PHASES        = 16;
    localparam int PHASE_TICKS   = 100;
    localparam int RANDOM_TICKS  = PHASES * PHASE_TICKS;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 400000;

    // Indexes past the register list; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [TENTHS_W-1:0] tenths;
        logic [2:0]          state;
        logic                beep;
    } reading_t;

    typedef struct packed {
        logic [CNT_W-1:0]     sample_p;
        logic [CNT_W-1:0]     check_p;
        logic [CNT_W-1:0]     beep_p;
        logic [LVL_CFG_W-1:0] nominal;
        logic [LVL_CFG_W-1:0] cutoff;
        logic [CONF_W-1:0]    confirm;
    } settings_t;

    // One row of the directed table: reload the fast pace first, the reading,
    // and a result typed in by hand where it is obvious
    typedef struct packed {
        logic           settle;
        logic [ADC_W-1:0] adc;
        logic           has_want;
        reading_t       want;
    } vector_t;

    // Sample, evaluate and beep on every tick; one confirming check
    localparam settings_t FAST_PACE = '{16'd0, 16'd0, 16'd0, 12'd1110, 12'd222, 3'd1};

    // The first five ticks run at reset pace and change nothing. Then the ring
    // fills with full-scale readings and drains with zeros, which walks the
    // machine through check, warning and normal and finally down to off.
    localparam vector_t DIRECTED [25] = '{
        '{1'b0, 10'd0,    1'b1, '{8'd0, PS_STARTUP, 1'b0}},
        '{1'b0, 10'd1023, 1'b1, '{8'd0, PS_STARTUP, 1'b0}},
        '{1'b0, 10'h155,  1'b1, '{8'd0, PS_STARTUP, 1'b0}},
        '{1'b0, 10'h2AA,  1'b1, '{8'd0, PS_STARTUP, 1'b0}},
        '{1'b0, 10'd1023, 1'b1, '{8'd0, PS_STARTUP, 1'b0}},
        '{1'b1, 10'd1023, 1'b0, '0},
        '{1'b0, 10'd1023, 1'b0, '0},
        '{1'b0, 10'd1023, 1'b0, '0},
        '{1'b0, 10'd1023, 1'b0, '0},
        '{1'b0, 10'd1023, 1'b0, '0},
        '{1'b0, 10'd1023, 1'b0, '0},
        '{1'b0, 10'd1023, 1'b0, '0},
        '{1'b0, 10'd1023, 1'b0, '0},
        '{1'b0, 10'd0,    1'b0, '0},
        '{1'b0, 10'd0,    1'b0, '0},
        '{1'b0, 10'd0,    1'b0, '0},
        '{1'b0, 10'd0,    1'b0, '0},
        '{1'b0, 10'd0,    1'b0, '0},
        '{1'b0, 10'd0,    1'b0, '0},
        '{1'b0, 10'd0,    1'b0, '0},
        '{1'b0, 10'd0,    1'b0, '0},
        '{1'b0, 10'd0,    1'b0, '0},
        '{1'b0, 10'd0,    1'b1, '{8'd5, PS_OFF, 1'b0}},
        '{1'b0, 10'd0,    1'b1, '{8'd5, PS_OFF, 1'b0}},
        '{1'b0, 10'd0,    1'b1, '{8'd5, PS_OFF, 1'b0}}
    };

    // Block ports
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [ADC_W-1:0]     adc_sample = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [TENTHS_W-1:0]  voltage_tenths;
    logic [2:0]           power_state;
    logic                 beep_start;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]     cfg_data = '0;

    // Hand-typed result that travels with the current input transaction
    logic     typed_row = 1'b0;
    reading_t typed_want = '0;

    // Monitor copy of the registers
    logic [CNT_W-1:0]     per_sample = RST_SAMPLE_PERIOD;
    logic [CNT_W-1:0]     per_check = RST_CHECK_PERIOD;
    logic [CNT_W-1:0]     per_beep = RST_BEEP_PERIOD;
    logic [LVL_CFG_W-1:0] lvl_nominal = RST_NOMINAL_LEVEL;
    logic [LVL_CFG_W-1:0] lvl_cutoff = RST_CUTOFF_LEVEL;
    logic [CONF_W-1:0]    n_confirm = RST_CONFIRM_CHECKS;

    // Monitor copy of the block state
    logic [ADC_W-1:0]    ring [WINDOW] = '{default: '0};
    logic [3:0]          ring_pos = '0;
    logic [13:0]         ring_total = '0;
    logic [LEVEL_W-1:0]  level = '0;
    logic [TENTHS_W-1:0] tenths = '0;
    mode_t               pred_mode = PS_STARTUP;
    logic [CONF_W-1:0]   confirm_count = '0;
    logic [CNT_W-1:0]    since_sample = '0;
    logic [CNT_W-1:0]    since_check = '0;
    logic [CNT_W-1:0]    since_beep = '0;

    reading_t pending_readings [$];
    reading_t predicted;
    reading_t oldest;
    int       fail_count = 0;
    int       cycle_count = 0;
    int       tx_idle_pct = 10;
    int       rx_idle_pct = 61;
    int       random_sent = 0;

    battery_voltage_monitor #(.WINDOW_LEN(WINDOW)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .adc_sample     (adc_sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .voltage_tenths (voltage_tenths),
        .power_state    (power_state),
        .beep_start     (beep_start),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #4 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // The receiver stalls at random at the current rate.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Advance the monitor state by one tick and return the expected result.
    function automatic reading_t predict_reading(input logic [ADC_W-1:0] adc);
        int       avg;
        int       m;
        int       t;
        int       lv;
        int       nom;
        int       cut;
        reading_t r;

        r = '0;
        since_sample = (since_sample == CNT_MAX) ? CNT_MAX : since_sample + 1'b1;
        since_check  = (since_check == CNT_MAX) ? CNT_MAX : since_check + 1'b1;
        since_beep   = (since_beep == CNT_MAX) ? CNT_MAX : since_beep + 1'b1;

        // Sampling: replace the oldest ring entry and rescale the average
        if (since_sample > per_sample)
        begin
            since_sample = '0;
            ring_total = 14'(int'(ring_total) - int'(ring[ring_pos]) + int'(adc));
            ring[ring_pos] = adc;
            ring_pos = (ring_pos == WINDOW - 1) ? 4'd0 : ring_pos + 4'd1;
            avg = int'(ring_total) / WINDOW;
            m = avg * int'(FULL_SCALE) / ADC_MAX;
            level = LEVEL_W'(m + int'(OFFSET_HUNDREDTHS));
            t = m / 10 + int'(TENTHS_BIAS);
            tenths = (t > int'(TENTHS_MAX)) ? TENTHS_MAX[7:0] : TENTHS_W'(t);
        end

        // Power machine step
        if (since_check > per_check)
        begin
            since_check = '0;
            lv = int'(level);
            nom = int'(lvl_nominal);
            cut = int'(lvl_cutoff);
            case (pred_mode)
                PS_OFF:
                begin
                    if (lv > cut)
                        pred_mode = PS_STARTUP;
                end
                PS_STARTUP:
                begin
                    pred_mode = (lv > nom) ? PS_NORMAL : PS_CHECK;
                end
                PS_NORMAL:
                begin
                    if (lv < nom)
                    begin
                        pred_mode = PS_CHECK;
                        confirm_count = '0;
                    end
                end
                PS_CHECK:
                begin
                    if (confirm_count < n_confirm)
                        confirm_count = confirm_count + 1'b1;
                    else if (lv < nom)
                        pred_mode = PS_WARNING;
                    if (lv >= nom)
                        pred_mode = PS_NORMAL;
                end
                PS_WARNING:
                begin
                    if (lv > nom)
                        pred_mode = PS_NORMAL;
                    if (lv < cut)
                        pred_mode = PS_OFF;
                end
                default:
                begin
                end
            endcase
        end

        // Beep pacing uses the state just computed
        if (pred_mode == PS_WARNING && since_beep >= per_beep)
        begin
            since_beep = '0;
            r.beep = 1'b1;
        end

        r.tenths = tenths;
        r.state = pred_mode;
        return r;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // Monitor: register writes, accepted ticks and accepted results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SAMPLE_PERIOD:  per_sample = cfg_data;
                    CFG_CHECK_PERIOD:   per_check = cfg_data;
                    CFG_BEEP_PERIOD:    per_beep = cfg_data;
                    CFG_NOMINAL_LEVEL:  lvl_nominal = cfg_data[LVL_CFG_W-1:0];
                    CFG_CUTOFF_LEVEL:   lvl_cutoff = cfg_data[LVL_CFG_W-1:0];
                    CFG_CONFIRM_CHECKS: n_confirm = cfg_data[CONF_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (in_valid && !in_stall)
            begin
                predicted = predict_reading(adc_sample);
                pending_readings.push_back(typed_row ? typed_want : predicted);
            end

            if (out_valid && !out_stall)
            begin
                if (pending_readings.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, got %0d/%0d/%0d",
                             $time, voltage_tenths, power_state, beep_start);
                end
                else
                begin
                    oldest = pending_readings.pop_front();
                    check_field("voltage_tenths", oldest.tenths, voltage_tenths);
                    check_field("power_state", oldest.state, power_state);
                    check_field("beep_start", oldest.beep, beep_start);
                end
            end
        end
    end

    function automatic logic [ADC_W-1:0] clamp_adc(input int v);
        if (v < 0)
            return '0;
        if (v > ADC_MAX)
            return ADC_W'(ADC_MAX);
        return ADC_W'(v);
    endfunction

    // Reading whose average lands near a level in hundredths of a volt.
    function automatic int level_to_adc(input int lvl);
        int a;

        a = (lvl > int'(OFFSET_HUNDREDTHS)) ?
            (lvl - int'(OFFSET_HUNDREDTHS)) * ADC_MAX / int'(FULL_SCALE) : 0;
        return int'(clamp_adc(a));
    endfunction

    // Offer one tick after any idle cycles and wait until it is taken. Each
    // cycle is idle at the current sender rate.
    task automatic send_tick(input logic [ADC_W-1:0] adc, input logic has_want,
                             input reading_t want);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        adc_sample <= adc;
        typed_row <= has_want;
        typed_want <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop sending and wait until every predicted result has come back. The
    // first edge lets the monitor queue the last accepted transaction.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Load a full register set while the block is idle. Unused upper bits of
    // the narrow registers carry junk, and one write goes past the list.
    task automatic program_settings(input settings_t s, input logic [CFG_IDX_W-1:0] spare);
        logic [CNT_W-1:0] junk;

        junk = CNT_W'($urandom);
        drain_results();
        write_reg(CFG_SAMPLE_PERIOD, s.sample_p);
        write_reg(CFG_CHECK_PERIOD, s.check_p);
        write_reg(CFG_BEEP_PERIOD, s.beep_p);
        write_reg(CFG_NOMINAL_LEVEL, {junk[15:12], s.nominal});
        write_reg(CFG_CUTOFF_LEVEL, {junk[11:8], s.cutoff});
        write_reg(CFG_CONFIRM_CHECKS, {junk[12:0], s.confirm});
        write_reg(spare, junk);
        cfg_we <= 1'b0;
    endtask

    // Register set for one random phase; some phases sit at the extremes.
    function automatic settings_t pick_settings(input int phase);
        settings_t s;

        s.sample_p = CNT_W'((phase % 4 == 3) ? $urandom_range(5, 40) : $urandom_range(0, 4));
        s.check_p  = CNT_W'($urandom_range(0, 12));
        s.beep_p   = CNT_W'($urandom_range(0, 25));
        s.nominal  = LVL_CFG_W'($urandom_range(400, 1700));
        s.cutoff   = LVL_CFG_W'($urandom_range(60, 600));
        s.confirm  = CONF_W'($urandom_range(0, 7));
        case (phase)
            2:  s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF, 3'd7};
            5:  s = '{16'd1, 16'd1, 16'd1, 12'd0, 12'd0, 3'd0};
            8:  s = '{16'd0, 16'd0, 16'd0, 12'hFFF, 12'd0, 3'd7};
            11: s = '{16'd0, 16'd2, 16'd0, 12'd0, 12'hFFF, 3'd0};
            14: s = '{16'd0, 16'd1, 16'hFFFF, 12'd1110, 12'd222, 3'd7};
            default:
            begin
            end
        endcase
        return s;
    endfunction

    initial
    begin
        settings_t pace;
        int        sent;
        int        seg_len;
        int        kind;
        int        base;
        int        spread;
        logic [ADC_W-1:0] adc;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].settle)
                program_settings(FAST_PACE, CFG_SPARE_A);
            send_tick(DIRECTED[i].adc, DIRECTED[i].has_want, DIRECTED[i].want);
        end

        // Random phases: runs of readings that hover around the thresholds,
        // with extremes, free random levels and pure noise mixed in
        for (int phase = 0; phase < PHASES; phase++)
        begin
            pace = pick_settings(phase);
            program_settings(pace, phase[0] ? CFG_SPARE_B : CFG_SPARE_A);
            sent = 0;
            while (sent < PHASE_TICKS)
            begin
                seg_len = $urandom_range(4, 40);
                kind = $urandom_range(0, 9);
                spread = $urandom_range(0, 30);
                if (kind <= 3)
                    base = level_to_adc(int'(pace.nominal) + $urandom_range(0, 120) - 60);
                else if (kind <= 5)
                    base = level_to_adc(int'(pace.cutoff) + $urandom_range(0, 120) - 60);
                else if (kind == 6)
                    base = $urandom_range(0, 1) ? ADC_MAX : 0;
                else
                    base = $urandom_range(0, ADC_MAX);
                for (int k = 0; k < seg_len && sent < PHASE_TICKS; k++)
                begin
                    // Idling pattern moves through its three stages
                    if (random_sent < RANDOM_TICKS / 3)
                    begin
                        tx_idle_pct = 10;
                        rx_idle_pct = 61;
                    end
                    else if (random_sent < 2 * RANDOM_TICKS / 3)
                    begin
                        tx_idle_pct = 61;
                        rx_idle_pct = 10;
                    end
                    else
                    begin
                        tx_idle_pct = 0;
                        rx_idle_pct = 0;
                    end
                    if (kind == 9)
                        adc = ADC_W'($urandom_range(0, ADC_MAX));
                    else
                        adc = clamp_adc(base + int'($urandom_range(0, 2 * spread)) - spread);
                    send_tick(adc, 1'b0, '0);
                    sent++;
                    random_sent++;
                end
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
